// ----- hw/rtl/rv32im_integer_alu_core_assert.svh -----
// Assertion macros shared by the checker of the integer ALU core.
`ifndef RV32IM_INTEGER_ALU_CORE_ASSERT_SVH
`define RV32IM_INTEGER_ALU_CORE_ASSERT_SVH

// Assert a property, disabled while reset is high.
`define RVALU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property at every edge, reset included.
`define RVALU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rvalu_pkg.sv -----
// Types and constants of the pipelined RV32IM integer ALU.
`timescale 1ns / 1ps
package rvalu_pkg;

   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES          = 32 / DIV_STEPS_PER_STAGE;
   localparam int LATENCY             = DIV_STAGES + 3;
   localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;

   typedef enum logic [4:0] {
      ACT_OR     = 5'd0,
      ACT_AND    = 5'd1,
      ACT_XOR    = 5'd2,
      ACT_ADD    = 5'd3,
      ACT_SUB    = 5'd4,
      ACT_SLL    = 5'd5,
      ACT_SRL    = 5'd6,
      ACT_SRA    = 5'd7,
      ACT_SLT    = 5'd8,
      ACT_SLTU   = 5'd9,
      ACT_JALR   = 5'd10,
      ACT_MULH   = 5'd11,
      ACT_MULHSU = 5'd12,
      ACT_MULHU  = 5'd13,
      ACT_MUL    = 5'd14,
      ACT_DIVU   = 5'd15,
      ACT_REMU   = 5'd16,
      ACT_DIV    = 5'd17,
      ACT_REM    = 5'd18
   } action_type;

   typedef struct packed {
      logic [31:0] res;
      logic        use_div;
      logic        want_rem;
      logic        neg_q;
      logic        neg_r;
   } ctl_type;

endpackage

// ----- hw/rtl/rvalu_div_pipe.sv -----
// Pipelined unsigned restoring divider, several quotient bits per stage.
`timescale 1ns / 1ps
module rvalu_div_pipe
   import rvalu_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic [31:0] quo,
   output logic [31:0] rem
);

   logic [31:0] r_ff [DIV_STAGES];
   logic [31:0] q_ff [DIV_STAGES];
   logic [31:0] d_ff [DIV_STAGES];

   function automatic logic [63:0] div_step(logic [31:0] r, logic [31:0] q, logic [31:0] d);
      logic [32:0] t;
      t = {r, q[31]};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         return {t[31:0], q[30:0], 1'b1};
      end
      return {t[31:0], q[30:0], 1'b0};
   endfunction

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [31:0] r_src, q_src, d_src;
      logic [31:0] r_in, q_in;
      logic [63:0] step;

      if (s == 0) begin : g_first
         assign r_src = '0;
         assign q_src = num;
         assign d_src = den;
      end else begin : g_next
         assign r_src = r_ff[s-1];
         assign q_src = q_ff[s-1];
         assign d_src = d_ff[s-1];
      end

      always_comb begin
         r_in = r_src;
         q_in = q_src;
         step = '0;
         for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
            step = div_step(r_in, q_in, d_src);
            r_in = step[63:32];
            q_in = step[31:0];
         end
      end

      always_ff @(posedge clock) begin
         r_ff[s] <= r_in;
         q_ff[s] <= q_in;
         d_ff[s] <= d_src;
      end
   end

   assign quo = q_ff[DIV_STAGES-1];
   assign rem = r_ff[DIV_STAGES-1];

endmodule

// ----- hw/rtl/rv32im_integer_alu_core.sv -----
// Top level of the pipelined RV32IM integer ALU.
`timescale 1ns / 1ps
// One operation is taken in every cycle (busy stays low) and its result
// appears on the rsp_ ports with rsp_strobe once it has passed the operand
// register, the front stage, the divider, which resolves four quotient bits
// in each of eight stages, and the output register; results leave in issue
// order and cannot be held off, and every operation travels the same depth.
module rv32im_integer_alu_core
   import rvalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_action,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result
);

   logic        s0_vld_ff;
   action_type  s0_act_ff;
   logic [31:0] s0_a_ff, s0_b_ff;

   logic        s1_vld_ff;
   action_type  s1_act_ff;
   logic [31:0] s1_res_ff, s1_res_in;
   logic [63:0] s1_prod_ff, s1_prod_in;
   logic [31:0] s1_num_ff, s1_num_in, s1_den_ff, s1_den_in;
   logic        s1_negq_ff, s1_negq_in, s1_negr_ff, s1_negr_in;

   logic        vld_ff [DIV_STAGES];
   ctl_type     ctl_ff [DIV_STAGES];
   ctl_type     ctl_in;

   logic [31:0] quo, rem;
   logic        out_vld_ff;
   logic [31:0] out_res_ff, out_res_in;

   logic [4:0]  sh;
   logic [31:0] sum;
   logic        sa, sb, sdiv;
   logic [32:0] ma, mb;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
      s0_act_ff <= action_type'(req_action);
      s0_a_ff   <= req_operand_a;
      s0_b_ff   <= req_operand_b;
   end

   always_comb begin
      sh   = s0_b_ff[4:0];
      sum  = s0_a_ff + s0_b_ff;
      sa   = s0_a_ff[31];
      sb   = s0_b_ff[31];
      sdiv = (s0_act_ff == ACT_DIV) || (s0_act_ff == ACT_REM);
      unique case (s0_act_ff)
         ACT_OR:   s1_res_in = s0_a_ff | s0_b_ff;
         ACT_AND:  s1_res_in = s0_a_ff & s0_b_ff;
         ACT_XOR:  s1_res_in = s0_a_ff ^ s0_b_ff;
         ACT_ADD:  s1_res_in = sum;
         ACT_SUB:  s1_res_in = s0_a_ff - s0_b_ff;
         ACT_SLL:  s1_res_in = s0_a_ff << sh;
         ACT_SRL:  s1_res_in = s0_a_ff >> sh;
         ACT_SRA:  s1_res_in = 32'($signed(s0_a_ff) >>> sh);
         ACT_SLT:  s1_res_in = {31'd0, $signed(s0_a_ff) < $signed(s0_b_ff)};
         ACT_SLTU: s1_res_in = {31'd0, s0_a_ff < s0_b_ff};
         ACT_JALR: s1_res_in = {sum[31:1], 1'b0};
         default:  s1_res_in = '0;
      endcase
      ma = {(sa && ((s0_act_ff == ACT_MULH) || (s0_act_ff == ACT_MULHSU))), s0_a_ff};
      mb = {(sb && (s0_act_ff == ACT_MULH)), s0_b_ff};
      s1_prod_in = 64'($signed(ma) * $signed(mb));
      s1_num_in  = (sdiv && sa) ? 32'(-s0_a_ff) : s0_a_ff;
      s1_den_in  = (sdiv && sb) ? 32'(-s0_b_ff) : s0_b_ff;
      s1_negq_in = sdiv && (sa ^ sb) && (s0_b_ff != '0);
      s1_negr_in = sdiv && sa;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_act_ff  <= s0_act_ff;
      s1_res_ff  <= s1_res_in;
      s1_prod_ff <= s1_prod_in;
      s1_num_ff  <= s1_num_in;
      s1_den_ff  <= s1_den_in;
      s1_negq_ff <= s1_negq_in;
      s1_negr_ff <= s1_negr_in;
   end

   always_comb begin
      ctl_in.res      = s1_res_ff;
      ctl_in.use_div  = 1'b0;
      ctl_in.want_rem = (s1_act_ff == ACT_REMU) || (s1_act_ff == ACT_REM);
      ctl_in.neg_q    = s1_negq_ff;
      ctl_in.neg_r    = s1_negr_ff;
      unique case (s1_act_ff)
         ACT_MULH, ACT_MULHSU, ACT_MULHU: ctl_in.res = s1_prod_ff[63:32];
         ACT_MUL:                         ctl_in.res = s1_prod_ff[31:0];
         ACT_DIVU, ACT_REMU, ACT_DIV, ACT_REM: ctl_in.use_div = 1'b1;
         default:                         ctl_in.res = s1_res_ff;
      endcase
   end

   rvalu_div_pipe u_div (
      .clock (clock),
      .num   (s1_num_ff),
      .den   (s1_den_ff),
      .quo   (quo),
      .rem   (rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= s1_vld_ff;
         for (int i = 1; i < DIV_STAGES; i++) vld_ff[i] <= vld_ff[i-1];
      end
      ctl_ff[0] <= ctl_in;
      for (int i = 1; i < DIV_STAGES; i++) ctl_ff[i] <= ctl_ff[i-1];
   end

   always_comb begin
      if (!ctl_ff[DIV_STAGES-1].use_div) begin
         out_res_in = ctl_ff[DIV_STAGES-1].res;
      end else if (ctl_ff[DIV_STAGES-1].want_rem) begin
         out_res_in = ctl_ff[DIV_STAGES-1].neg_r ? 32'(-rem) : rem;
      end else begin
         out_res_in = ctl_ff[DIV_STAGES-1].neg_q ? 32'(-quo) : quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[DIV_STAGES-1];
      end
      out_res_ff <= out_res_in;
   end

   assign rsp_strobe = out_vld_ff;
   assign rsp_result = out_res_ff;

endmodule

// ----- hw/rtl/rvalu_checker.sv -----
// Port-level checker of the integer ALU core and its bind.
`timescale 1ns / 1ps
`include "rv32im_integer_alu_core_assert.svh"
module rvalu_checker
   import rvalu_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   `RVALU_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_strobe, "beat after reset")
   `RVALU_ASSERT(a_never_busy, clock, reset, !busy, "busy raised")
   `RVALU_ASSERT(a_beat_follows, clock, reset, (start && !busy) |-> ##11 rsp_strobe, "beat lost")
   `RVALU_ASSERT(a_beat_caused, clock, reset, rsp_strobe |-> $past(start && !busy, 11),
      "beat invented")

endmodule

bind rv32im_integer_alu_core rvalu_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

// ----- tb/sv/rv32im_integer_alu_core_tb.sv -----
// Self-checking testbench of the pipelined RV32IM integer ALU core.
`timescale 1ns / 1ps
module rv32im_integer_alu_core_tb;
   import rvalu_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   typedef struct {
      logic [4:0]  action;
      logic [31:0] a;
      logic [31:0] b;
   } alu_op_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [4:0]  req_action;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic        rsp_strobe;
   logic [31:0] rsp_result;

   alu_op_t     pending_ops[$];
   logic [31:0] expected_results[$];
   int          errors = 0;
   int          gap = 0;
   int          idle_cycles = 0;
   bit          stim_done = 0;

   rv32im_integer_alu_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .rsp_strobe(rsp_strobe),
      .rsp_result(rsp_result)
   );

   function automatic logic [31:0] alu_result(logic [4:0] op, logic [31:0] a,
                                              logic [31:0] b);
      logic [63:0] prod;
      logic [4:0]  sh;
      sh = b[4:0];
      case (op)
         ACT_OR:     return a | b;
         ACT_AND:    return a & b;
         ACT_XOR:    return a ^ b;
         ACT_ADD:    return a + b;
         ACT_SUB:    return a - b;
         ACT_SLL:    return a << sh;
         ACT_SRL:    return a >> sh;
         ACT_SRA:    return 32'($signed(a) >>> sh);
         ACT_SLT:    return {31'd0, $signed(a) < $signed(b)};
         ACT_SLTU:   return {31'd0, a < b};
         ACT_JALR:   return (a + b) & ~32'd1;
         ACT_MULH: begin
            prod = 64'($signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b}));
            return prod[63:32];
         end
         ACT_MULHSU: begin
            prod = 64'({{32{a[31]}}, a} * {32'd0, b});
            return prod[63:32];
         end
         ACT_MULHU: begin
            prod = {32'd0, a} * {32'd0, b};
            return prod[63:32];
         end
         ACT_MUL:    return a * b;
         ACT_DIVU:   return (b == 0) ? 32'hFFFF_FFFF : a / b;
         ACT_REMU:   return (b == 0) ? a : a % b;
         ACT_DIV: begin
            if (b == 0) return 32'hFFFF_FFFF;
            if (a == MOST_NEGATIVE && b == 32'hFFFF_FFFF) return MOST_NEGATIVE;
            return 32'($signed(a) / $signed(b));
         end
         ACT_REM: begin
            if (b == 0) return a;
            if (a == MOST_NEGATIVE && b == 32'hFFFF_FFFF) return 32'd0;
            return 32'($signed(a) % $signed(b));
         end
         default:    return 32'd0;
      endcase
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return MOST_NEGATIVE;
         3: return $urandom_range(0, 15);
         4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      alu_op_t op;
      logic [31:0] edge_vals[6];
      edge_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, MOST_NEGATIVE, 32'h7FFF_FFFF, 32'd37};
      for (int i = 0; i < 19; i++) begin
         op.action = 5'(i);
         op.a = edge_vals[i % 6];
         op.b = edge_vals[(i + 2) % 6];
         pending_ops.push_back(op);
      end
      pending_ops.push_back('{ACT_DIV, MOST_NEGATIVE, 32'hFFFF_FFFF});
      pending_ops.push_back('{ACT_REM, MOST_NEGATIVE, 32'hFFFF_FFFF});
      pending_ops.push_back('{ACT_DIV, 32'hFFFF_FFF9, 32'd0});
      pending_ops.push_back('{ACT_REMU, 32'd1234, 32'd0});
      pending_ops.push_back('{ACT_REM, 32'hFFFF_FFF9, 32'd2});
      pending_ops.push_back('{5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      for (int i = 0; i < 900; i++) begin
         op.action = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(19, 31))
                                                   : 5'($urandom_range(0, 18));
         op.a = rand_operand();
         op.b = rand_operand();
         pending_ops.push_back(op);
      end
      stim_done = 1;
   end

   initial begin
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req_action <= '0;
         req_operand_a <= '0;
         req_operand_b <= '0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(alu_result(req_action, req_operand_a,
                                                  req_operand_b));
            gap = rand_gap();
         end
         if (start && busy) begin
            // hold the beat
         end else if (gap > 0) begin
            gap--;
            start <= 0;
         end else if (pending_ops.size() > 0) begin
            alu_op_t op;
            op = pending_ops.pop_front();
            start <= 1;
            req_action <= op.action;
            req_operand_a <= op.a;
            req_operand_b <= op.b;
         end else begin
            start <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected beat, actual %h", $time, rsp_result);
               errors++;
            end else begin
               logic [31:0] exp_res;
               exp_res = expected_results.pop_front();
               if (rsp_result !== exp_res) begin
                  $display("%0t: result mismatch, expected %h actual %h",
                           $time, exp_res, rsp_result);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      start = 0;
      req_action = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      wait (stim_done);
      @(posedge clock);
      while ((pending_ops.size() > 0 || start || expected_results.size() > 0)
             && idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL rv32im_integer_alu_core");
      end else begin
         repeat (LATENCY + 10) @(posedge clock);
         if (errors == 0) $display("PASS rv32im_integer_alu_core");
         else $display("FAIL rv32im_integer_alu_core");
      end
      $finish;
   end

endmodule
